// ----- hdl/pbo_pkg.sv -----
// Shared types and constants of the band-limited oscillator.
package pbo_pkg;

  localparam int PHASE_W    = 32;
  localparam int INC_W      = 31;
  localparam int TIME_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int SINE_DEPTH = 256;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);
  localparam int DIV_QW     = 30;
  localparam int MUL_W      = 34;
  localparam int V_W        = 40;
  localparam int ACC_W      = 64;
  localparam int CFG_W      = 31;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] PI_Q30  = 31'd1686629713;

  typedef enum logic {
    ACT_NEXT    = 1'b0,
    ACT_AT_TIME = 1'b1
  } act_t;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_TRI    = 2'd3
  } wave_t;

  typedef enum logic {
    CFG_INC  = 1'b0,
    CFG_WAVE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] time_req;
  } pbo_item_t;

  typedef struct packed {
    logic             start;
    logic [INC_W-1:0] num;
    logic [INC_W-1:0] den;
  } pbo_div_req_t;

endpackage

// ----- hdl/pbo_front.sv -----
// Input side: accepts requests and queues them for the compute engine.
module pbo_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [31:0]        in_time_req,
  output logic               q_valid,
  output pbo_pkg::pbo_item_t q_item,
  input  logic               q_pop
);
  import pbo_pkg::*;

  pbo_item_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{action: in_action, time_req: in_time_req};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      case ({push, q_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- hdl/pbo_div.sv -----
// Restoring divider for the residual ratio, two quotient bits per cycle.
module pbo_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pbo_pkg::pbo_div_req_t       req,
  output logic                        done,
  output logic [pbo_pkg::DIV_QW-1:0]  quo
);
  import pbo_pkg::*;

  localparam int ITERS = DIV_QW / 2;

  logic              busy_r, done_r;
  logic [3:0]        cnt_r;
  logic [31:0]       rem_r;
  logic [DIV_QW-1:0] q_r;
  logic [INC_W-1:0]  den_r;
  logic [31:0]       s1, r1, s2, r2;
  logic              b1, b2;

  // The remainder stays below the divisor, so doubling it never overflows 32 bits.
  always_comb begin
    s1 = {rem_r[30:0], 1'b0};
    b1 = (s1 >= {1'b0, den_r});
    r1 = b1 ? s1 - {1'b0, den_r} : s1;
    s2 = {r1[30:0], 1'b0};
    b2 = (s2 >= {1'b0, den_r});
    r2 = b2 ? s2 - {1'b0, den_r} : s2;
  end

  assign done = done_r;
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.num};
      den_r <= req.den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= r2;
      q_r   <= {q_r[DIV_QW-3:0], b1, b2};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == 4'(ITERS - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(ITERS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hdl/pbo_sine.sv -----
// Quarter-wave sine table, built at elaboration, and quadrant folding.
module pbo_sine (
  input  logic        [31:0] t,
  output logic signed [31:0] v
);
  import pbo_pkg::*;

  logic [30:0]        rom [SINE_DEPTH];
  logic [SINE_AW-1:0] p;
  logic [30:0]        e;

  for (genvar i = 0; i < SINE_DEPTH; i++) begin : g_rom
    localparam longint X  = ((2 * i + 1) * 64'd1686629713) / (2 * SINE_DEPTH);
    localparam longint X2 = (X * X) >>> 30;
    localparam longint T1 = ((X * X2) >>> 30) / 6;
    localparam longint T2 = ((T1 * X2) >>> 30) / 20;
    localparam longint T3 = ((T2 * X2) >>> 30) / 42;
    localparam longint T4 = ((T3 * X2) >>> 30) / 72;
    localparam longint T5 = ((T4 * X2) >>> 30) / 110;
    localparam longint T6 = ((T5 * X2) >>> 30) / 156;
    localparam longint S  = X - T1 + T2 - T3 + T4 - T5 + T6;
    localparam longint SC = (S < 0) ? 0 : ((S > 64'h4000_0000) ? 64'h4000_0000 : S);
    assign rom[i] = 31'(SC);
  end

  always_comb begin
    p = t[29 -: SINE_AW];
    if (t[30]) p = ~p;
    e = rom[p];
    v = t[31] ? -$signed({1'b0, e}) : $signed({1'b0, e});
  end

endmodule

// ----- hdl/pbo_back.sv -----
// Compute engine: phase update, residuals, triangle integrator and output register.
module pbo_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pbo_pkg::INC_W-1:0]   inc,
  input  pbo_pkg::wave_t              wave,
  input  logic                        q_valid,
  input  pbo_pkg::pbo_item_t          q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          out_sample
);
  import pbo_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MULPH = 10'b0000000010,
    S_PREP  = 10'b0000000100,
    S_RES   = 10'b0000001000,
    S_DIVW  = 10'b0000010000,
    S_SQ    = 10'b0000100000,
    S_MULA  = 10'b0001000000,
    S_MULAV = 10'b0010000000,
    S_MULPV = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t                   state_r;
  logic [PHASE_W-1:0]       phase_r, t_r;
  logic [TIME_W-1:0]        time_r;
  logic signed [SAMPLE_W-1:0] last_r;
  logic signed [V_W-1:0]    v_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [25:0]              a_r;
  logic                     pass_r, neg_r;
  logic                     out_valid_r;
  logic signed [15:0]       out_sample_r;

  logic signed [MUL_W-1:0]   mul_x, mul_y;
  logic signed [2*MUL_W-1:0] prod;
  logic signed [31:0]        sine_v;
  pbo_div_req_t              div_req;
  logic                      div_done;
  logic [DIV_QW-1:0]         div_q;
  logic [31:0]               tt, n_hi;
  logic                      win_lo, win_hi, sub, last_pass, out_free;
  logic [30:0]               u, m;
  logic signed [V_W:0]       rnd;
  logic signed [V_W-15:0]    shr;
  logic signed [15:0]        sat;
  logic signed [2*MUL_W-1:0] tri_sum;

  pbo_sine u_sine (.t(t_r), .v(sine_v));

  pbo_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .quo(div_q)
  );

  // Residual window of the current pass; the second pass looks half a waveform period ahead.
  always_comb begin
    tt     = pass_r ? t_r + 32'h8000_0000 : t_r;
    win_lo = (tt < {1'b0, inc});
    win_hi = (inc != '0) && (({1'b0, tt} + {2'b0, inc}) > 33'h1_0000_0000);
    n_hi   = 32'(33'h1_0000_0000 - {1'b0, tt});
    sub    = (wave == WAVE_SAW) || pass_r;
    last_pass = pass_r || (wave == WAVE_SAW);
    div_req.start = (state_r == S_RES) && (win_lo || win_hi);
    div_req.num   = win_lo ? tt[INC_W-1:0] : n_hi[INC_W-1:0];
    div_req.den   = inc;
    u = Q30_ONE - {1'b0, div_q};
  end

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state_r)
      S_MULPH: begin
        mul_x = $signed({2'b0, time_r});
        mul_y = $signed({3'b0, inc});
      end
      S_SQ: begin
        mul_x = $signed({3'b0, u});
        mul_y = $signed({3'b0, u});
      end
      S_MULA: begin
        mul_x = $signed({3'b0, inc});
        mul_y = $signed({3'b0, PI_Q30});
      end
      S_MULAV: begin
        mul_x = $signed({8'b0, a_r});
        mul_y = v_r[MUL_W-1:0];
      end
      S_MULPV: begin
        mul_x = $signed(34'h100_0000) - $signed({8'b0, a_r});
        mul_y = MUL_W'($signed({last_r, 15'b0}));
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
    prod    = mul_x * mul_y;
    m       = prod[60:30];
    tri_sum = 68'(acc_r) + prod;
  end

  // Round to the output format and saturate.
  always_comb begin
    rnd = 41'(v_r) + 41'sd16384;
    shr = rnd[V_W:15];
    if (shr > 26'sd32767) sat = 16'sh7fff;
    else if (shr < -26'sd32768) sat = -16'sh8000;
    else sat = shr[15:0];
  end

  assign out_free   = !out_valid_r || out_ready;
  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        time_r <= q_item.time_req;
        t_r    <= phase_r;
      end
      S_MULPH: t_r <= prod[31:0];
      S_PREP: begin
        pass_r <= 1'b0;
        case (wave)
          WAVE_SINE: v_r <= V_W'(sine_v);
          WAVE_SAW:  v_r <= $signed({9'b0, t_r[31:1]}) - $signed({9'b0, Q30_ONE});
          default:   v_r <= t_r[31] ? -$signed({9'b0, Q30_ONE}) : $signed({9'b0, Q30_ONE});
        endcase
      end
      S_RES: begin
        neg_r <= win_lo;
        if (!(win_lo || win_hi) && !last_pass) pass_r <= 1'b1;
      end
      S_SQ: begin
        if (neg_r == sub) v_r <= v_r + $signed({9'b0, m});
        else v_r <= v_r - $signed({9'b0, m});
        if (!last_pass) pass_r <= 1'b1;
      end
      S_MULA:  a_r   <= prod[61:36];
      S_MULAV: acc_r <= prod[ACC_W-1:0];
      S_MULPV: v_r   <= tri_sum[V_W+23:24];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.action == ACT_AT_TIME) begin
              state_r <= S_MULPH;
            end else begin
              phase_r <= phase_r + {1'b0, inc};
              state_r <= S_PREP;
            end
          end
        end
        S_MULPH: begin
          phase_r <= prod[31:0];
          state_r <= S_PREP;
        end
        S_PREP: state_r <= (wave == WAVE_SINE) ? S_FIN : S_RES;
        S_RES: begin
          if (win_lo || win_hi) state_r <= S_DIVW;
          else if (!last_pass) state_r <= S_RES;
          else state_r <= (wave == WAVE_TRI) ? S_MULA : S_FIN;
        end
        S_DIVW: if (div_done) state_r <= S_SQ;
        S_SQ: begin
          if (!last_pass) state_r <= S_RES;
          else state_r <= (wave == WAVE_TRI) ? S_MULA : S_FIN;
        end
        S_MULA:  state_r <= S_MULAV;
        S_MULAV: state_r <= S_MULPV;
        S_MULPV: state_r <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            if (wave == WAVE_TRI) last_r <= sat;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) out_sample_r <= sat;
  end

endmodule

// ----- hdl/polyblep_oscillator.sv -----
// Top level of the band-limited oscillator.
// Each request yields one Q1.15 sample. The input queue holds two requests, so
// the caller can keep issuing while the engine computes and while a finished sample
// waits on the output. The engine handles one request at a time. A sine sample is
// read from the table directly; saw, square and triangle also check residual
// windows and run the residual divider when one is hit, and a triangle then runs
// the integrator. A timed request first computes its phase, and a finished sample
// may wait on the output. The residual divider produces two quotient bits per
// cycle (15 iterations per residual), and a single shared multiplier serves the
// phase, the residual square and the triangle integrator. Write the configuration
// only while no request is outstanding.
module polyblep_oscillator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [31:0]        in_time_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_wdata
);
  import pbo_pkg::*;

  logic [INC_W-1:0] inc_r;
  wave_t            wave_r;
  logic             q_valid, q_pop;
  pbo_item_t        q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r  <= '0;
      wave_r <= WAVE_SINE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INC:  inc_r  <= cfg_wdata;
        CFG_WAVE: wave_r <= wave_t'(cfg_wdata[1:0]);
        default:  ;
      endcase
    end
  end

  pbo_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_time_req(in_time_req),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  pbo_back u_back (
    .clk(clk), .rst_n(rst_n),
    .inc(inc_r), .wave(wave_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_sample(out_sample)
  );

endmodule
